### rtl/source_comment_whitespace_filter_top_defines.svh
// Assertion macros shared by the checker of the comment and whitespace filter.
// No dependencies; included by the checker file only.
`ifndef SOURCE_COMMENT_WHITESPACE_FILTER_TOP_DEFINES_SVH
`define SOURCE_COMMENT_WHITESPACE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define SCWF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scwf check failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define SCWF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scwf check failed");

`endif

### rtl/scwf_pkg.sv
// Shared types, character codes and helpers for the comment and whitespace filter.
// No dependencies; imported by every module of the block.
package scwf_pkg;

   // Character codes the scanner looks for
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Control register indexes
   localparam logic [1:0] CFG_STRIP_COMMENTS   = 2'd0;
   localparam logic [1:0] CFG_STRIP_NEWLINES   = 2'd1;
   localparam logic [1:0] CFG_STRIP_WHITESPACE = 2'd2;

   typedef struct packed {
      logic strip_comments;
      logic strip_newlines;
      logic strip_whitespace;
   } cfg_type;

   // Up to two bytes released by one input beat
   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] b0;
      logic [7:0] b1;
   } pair_type;

   // Newline and whitespace filters: 1 when the byte survives
   function automatic logic keep_char(cfg_type cfg, logic [7:0] c);
      logic drop_nl;
      logic drop_ws;
      drop_nl = cfg.strip_newlines && (c == CH_LF);
      drop_ws = cfg.strip_whitespace && ((c == CH_SPACE) || (c == CH_TAB));
      return !(drop_nl || drop_ws);
   endfunction

endpackage

### rtl/source_comment_whitespace_filter_top.sv
// Accepted beats pass through the input register into the result register, which
// drives rsp. One input beat per cycle while rsp is not stalled; a beat that
// releases two bytes holds the result register until both leave; the input stalls.
// Reset (synchronous, active high) clears all three filter enables, returns the
// scanner to normal text and empties the input and result registers.
// Depends on scwf_pkg, scwf_scanner and scwf_out_stage.
module source_comment_whitespace_filter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [0:0] csr_wdata
);
   import scwf_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_char_ff;
   logic [7:0] in_char_in;
   logic       in_eot_ff;
   logic       in_eot_in;
   logic       res_free;
   logic       advance;
   logic       req_take;
   pair_type   pair;

   // Control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CFG_STRIP_COMMENTS:   cfg_in.strip_comments   = csr_wdata[0];
            CFG_STRIP_NEWLINES:   cfg_in.strip_newlines   = csr_wdata[0];
            CFG_STRIP_WHITESPACE: cfg_in.strip_whitespace = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register moves into the result register when that one frees up
   assign advance   = in_valid_ff && res_free;
   assign req_stall = in_valid_ff && !res_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_char_in  = req_take ? req_in_char : in_char_ff;
      in_eot_in   = req_take ? req_end_of_text : in_eot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_eot_ff  <= in_eot_in;
   end

   scwf_scanner u_scanner (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_char (in_char_ff),
      .in_eot  (in_eot_ff),
      .advance (advance),
      .pair    (pair)
   );

   scwf_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .pair         (pair),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last),
      .free         (res_free)
   );

endmodule

### rtl/scwf_scanner.sv
// Comment scanner: mode register plus the per-byte decode into a byte pair.
// Depends on scwf_pkg.
module scwf_scanner (
   input  logic               clock,
   input  logic               reset,
   input  scwf_pkg::cfg_type  cfg,
   input  logic [7:0]         in_char,
   input  logic               in_eot,
   input  logic               advance,
   output scwf_pkg::pair_type pair
);
   import scwf_pkg::*;

   localparam logic [2:0] MODE_NORMAL     = 3'd0;
   localparam logic [2:0] MODE_SLASH      = 3'd1;
   localparam logic [2:0] MODE_BLOCK      = 3'd2;
   localparam logic [2:0] MODE_BLOCK_STAR = 3'd3;
   localparam logic [2:0] MODE_LINE       = 3'd4;

   logic [2:0] mode_ff;
   logic [2:0] mode_in;
   logic [2:0] mode_scan;
   logic       pre_slash;
   logic       emit_char;
   logic       post_slash;
   logic       keep;

   // Mode transition and which bytes this beat releases
   always_comb begin
      pre_slash  = 1'b0;
      emit_char  = 1'b0;
      post_slash = 1'b0;
      mode_scan  = mode_ff;
      if (!cfg.strip_comments) begin
         pre_slash = (mode_ff == MODE_SLASH);
         emit_char = 1'b1;
         mode_scan = MODE_NORMAL;
      end else begin
         unique case (mode_ff)
            MODE_SLASH: begin
               if (in_char == CH_STAR) begin
                  mode_scan = MODE_BLOCK;
               end else if (in_char == CH_SLASH) begin
                  mode_scan = MODE_LINE;
               end else begin
                  pre_slash = 1'b1;
                  emit_char = 1'b1;
                  mode_scan = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (in_char == CH_STAR) mode_scan = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (in_char == CH_SLASH) mode_scan = MODE_NORMAL;
               else if (in_char != CH_STAR) mode_scan = MODE_BLOCK;
            end
            MODE_LINE: begin
               // the line feed that closes a line comment is kept unless the newline filter strips it
               if (in_char == CH_LF) begin
                  emit_char = 1'b1;
                  mode_scan = MODE_NORMAL;
               end
            end
            default: begin
               if (in_char == CH_SLASH) begin
                  mode_scan = MODE_SLASH;
               end else begin
                  emit_char = 1'b1;
                  mode_scan = MODE_NORMAL;
               end
            end
         endcase
      end
      // End of text flushes a held slash and drops any open comment
      if (in_eot) begin
         post_slash = (mode_scan == MODE_SLASH);
         mode_scan  = MODE_NORMAL;
      end
   end

   // A held slash and the end-of-text slash never occur together
   always_comb begin
      keep     = emit_char && keep_char(cfg, in_char);
      pair.cnt = {1'b0, pre_slash} + {1'b0, keep} + {1'b0, post_slash};
      pair.b0  = (pre_slash || post_slash) ? CH_SLASH : in_char;
      pair.b1  = in_char;
      mode_in  = advance ? mode_scan : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

### rtl/scwf_out_stage.sv
// Result register: holds a byte pair and hands it out one beat at a time.
// Depends on scwf_pkg.
module scwf_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  scwf_pkg::pair_type pair,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_run_last,
   output logic               free
);
   import scwf_pkg::*;

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [7:0] b0_ff;
   logic [7:0] b0_in;
   logic [7:0] b1_ff;
   logic [7:0] b1_in;
   logic       take;

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_char = b0_ff;
   assign rsp_run_last = (cnt_ff == 2'd1);
   assign take         = rsp_valid && !rsp_stall;
   // free when empty or the final byte leaves this cycle
   assign free         = (cnt_ff == 2'd0) || (rsp_run_last && !rsp_stall);

   // Load a new pair, or shift the second byte forward after a beat
   always_comb begin
      cnt_in = cnt_ff;
      b0_in  = b0_ff;
      b1_in  = b1_ff;
      if (load) begin
         cnt_in = pair.cnt;
         b0_in  = pair.b0;
         b1_in  = pair.b1;
      end else if (take) begin
         cnt_in = cnt_ff - 2'd1;
         b0_in  = b1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b0_ff <= b0_in;
      b1_ff <= b1_in;
   end

endmodule

### rtl/scwf_checker.sv
// Port-level checks for the comment and whitespace filter, bound to the top level.
// Depends on scwf_pkg and source_comment_whitespace_filter_top_defines.svh.
`include "source_comment_whitespace_filter_top_defines.svh"

module scwf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_last
);
   import scwf_pkg::*;

   // A two-byte run always starts with a released slash
   `SCWF_ASSERT_NOW(a_pair_head_slash, rsp_valid && !rsp_run_last, rsp_out_char == CH_SLASH)

   // The second byte of a run follows right after the first beat
   `SCWF_ASSERT_NEXT(a_pair_tail_follows, rsp_valid && !rsp_run_last && !rsp_stall, rsp_valid && rsp_run_last)

   // A stalled result beat holds
   `SCWF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_char) && $stable(rsp_run_last))

endmodule

bind source_comment_whitespace_filter_top scwf_checker u_scwf_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_run_last (rsp_run_last)
);
